// ===== rtl/core/amx_pkg.sv =====
// Shared constants for the AdaMax parameter update block.
`timescale 1ns / 1ps

package amx_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int RATE_BITS   = 16;
    localparam int POWER_BITS  = 32;
    localparam int SCALE_BITS  = 48;
    localparam int SCALE_FRAC  = 32;
    localparam int SCALE_SPLIT = SCALE_BITS / 2;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [RATE_BITS:0]    RATE_ONE  = 17'h1_0000;
    localparam logic [POWER_BITS-1:0] POWER_ONE = 32'h8000_0000;
    localparam logic [SCALE_BITS-1:0] SCALE_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [RATE_BITS-1:0] LEARNING_RATE_RST = 16'd131;
    localparam logic [RATE_BITS-1:0] DECAY_RATE_RST    = 16'd0;
    localparam logic [RATE_BITS-1:0] MOMENT_RATE_RST   = 16'd58982;
    localparam logic [RATE_BITS-1:0] NORM_RATE_RST     = 16'd65470;

    localparam logic [CFG_IDX_BITS-1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_RATE    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOMENT_RATE   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_NORM_RATE     = 2'd3;

endpackage

// ===== rtl/core/adamax_parameter_update.sv =====
// AdaMax parameter update: streaming element pipeline with step scale sequencer.
// Pipeline: stages A to G, the divider input register, the divider stages and the output register.
// Throughput: one element per cycle while in_stall is low; the restoring divider has one
// stage per quotient bit. An element with start_of_pass is held by in_stall while the step
// scale is recomputed by a serial divider (one quotient bit per cycle, 48 bits).
// Reset clears valid bits, config registers to defaults, beta1 power to 1.0, scale to 0.
`timescale 1ns / 1ps

module adamax_parameter_update #(
    parameter int DATA_WIDTH = amx_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = amx_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [amx_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [amx_pkg::RATE_BITS-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 start_of_pass,
    input  logic                                 is_bias,
    input  logic signed [DATA_WIDTH-1:0]         gradient,
    input  logic signed [DATA_WIDTH-1:0]         param_value,
    input  logic signed [DATA_WIDTH-1:0]         first_moment,
    input  logic [DATA_WIDTH-2:0]                max_norm,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [DATA_WIDTH-1:0]         new_param_value,
    output logic signed [DATA_WIDTH-1:0]         new_first_moment,
    output logic [DATA_WIDTH-2:0]                new_max_norm,
    output logic                                 zero_norm
);

    localparam int W   = DATA_WIDTH;
    localparam int UW  = DATA_WIDTH - 1;
    localparam int RB  = amx_pkg::RATE_BITS;
    localparam int SB  = amx_pkg::SCALE_BITS;
    localparam int SP  = amx_pkg::SCALE_SPLIT;
    localparam int PW  = W + SB;
    localparam int SH  = amx_pkg::SCALE_FRAC - FRAC_BITS;
    localparam int NW  = PW - SH;
    localparam int HW  = NW - W;
    localparam int CW  = (HW > W) ? HW : W;
    localparam int PB  = amx_pkg::POWER_BITS;

    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [UW-1:0]       UMAX = {UW{1'b1}};
    localparam logic [W-1:0]        CAP  = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_DONE} sstate_t;

    typedef struct packed {
        logic signed [W-1:0] w;
        logic signed [W-1:0] mn;
        logic [UW-1:0]       un;
        logic                pos;
        logic                neg;
        logic                zero;
        logic                ovf;
    } side_t;

    typedef struct packed {
        logic signed [W-1:0] wn;
        logic signed [W-1:0] mn;
        logic [UW-1:0]       un;
        logic                zero;
    } res_t;

    // configuration registers
    logic [RB-1:0] learning_rate_reg, decay_rate_reg, moment_rate_reg, norm_rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg <= amx_pkg::LEARNING_RATE_RST;
            decay_rate_reg    <= amx_pkg::DECAY_RATE_RST;
            moment_rate_reg   <= amx_pkg::MOMENT_RATE_RST;
            norm_rate_reg     <= amx_pkg::NORM_RATE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                amx_pkg::REG_LEARNING_RATE: learning_rate_reg <= cfg_data;
                amx_pkg::REG_DECAY_RATE:    decay_rate_reg    <= cfg_data;
                amx_pkg::REG_MOMENT_RATE:   moment_rate_reg   <= cfg_data;
                amx_pkg::REG_NORM_RATE:     norm_rate_reg     <= cfg_data;
                default:                    learning_rate_reg <= learning_rate_reg;
            endcase
        end
    end

    // pipeline control
    logic skid_valid_reg;
    logic advance;
    logic accept;
    sstate_t sstate_reg;

    assign advance  = !skid_valid_reg;
    assign in_stall = !advance || (in_valid && start_of_pass && (sstate_reg != S_DONE));
    assign accept   = in_valid && !in_stall;

    // step scale sequencer
    logic [PB-1:0]   power_reg;
    logic [SB-1:0]   scale_reg;
    logic [PB-1:0]   sdiv_rem_reg;
    logic [SB-1:0]   sdiv_q_reg;
    logic [5:0]      sdiv_cnt_reg;
    logic [PB-1:0]   factor;
    logic [PB-1:0]   eta_half;
    logic [PB+RB-1:0] power_prod;
    logic            sdiv_bit;
    logic [PB:0]     sdiv_trial;
    logic            sdiv_take;

    assign power_prod = power_reg * moment_rate_reg;
    assign factor     = amx_pkg::POWER_ONE - power_reg;
    assign eta_half   = PB'(learning_rate_reg >> 1);
    assign sdiv_bit   = (sdiv_cnt_reg == 6'd0) ? learning_rate_reg[0] : 1'b0;
    assign sdiv_trial = {sdiv_rem_reg, sdiv_bit};
    assign sdiv_take  = sdiv_trial >= {1'b0, factor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sstate_reg   <= S_IDLE;
            power_reg    <= amx_pkg::POWER_ONE;
            scale_reg    <= '0;
            sdiv_rem_reg <= '0;
            sdiv_q_reg   <= '0;
            sdiv_cnt_reg <= '0;
        end
        else
        begin
            case (sstate_reg)
                S_IDLE:
                begin
                    if (in_valid && start_of_pass)
                    begin
                        power_reg  <= PB'(power_prod >> RB);
                        sstate_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (eta_half >= factor)
                    begin
                        scale_reg  <= amx_pkg::SCALE_MAX;
                        sstate_reg <= S_DONE;
                    end
                    else
                    begin
                        sdiv_rem_reg <= eta_half;
                        sdiv_q_reg   <= '0;
                        sdiv_cnt_reg <= '0;
                        sstate_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    sdiv_rem_reg <= sdiv_take ? PB'(sdiv_trial - {1'b0, factor})
                                              : PB'(sdiv_trial);
                    sdiv_q_reg   <= {sdiv_q_reg[SB-2:0], sdiv_take};
                    sdiv_cnt_reg <= sdiv_cnt_reg + 6'd1;
                    if (sdiv_cnt_reg == 6'(SB - 1))
                    begin
                        scale_reg  <= {sdiv_q_reg[SB-2:0], sdiv_take};
                        sstate_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (accept)
                    begin
                        sstate_reg <= S_IDLE;
                    end
                end
                default: sstate_reg <= S_IDLE;
            endcase
        end
    end

    // stage valid bits
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, g_v_reg;
    logic dv_reg [0:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            dv_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            a_v_reg <= accept;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            dv_reg[0] <= g_v_reg;
        end
    end

    // stage A: capture
    logic                a_bias_reg;
    logic signed [W-1:0] a_g_reg, a_w_reg, a_m_reg;
    logic [UW-1:0]       a_u_reg;
    logic [SB-1:0]       a_scale_reg;

    // stage B: weight decay product
    logic                  b_bias_reg;
    logic signed [W-1:0]   b_g_reg, b_w_reg, b_m_reg;
    logic [UW-1:0]         b_u_reg;
    logic [SB-1:0]         b_scale_reg;
    logic signed [W+16:0]  b_dec_reg;

    // stage C: decayed gradient
    logic signed [W-1:0]   c_g_reg, c_w_reg, c_m_reg;
    logic [UW-1:0]         c_u_reg;
    logic [SB-1:0]         c_scale_reg;
    logic signed [W+17:0]  c_sum;
    logic signed [W-1:0]   c_g_sat;

    // stage D: moment and norm products
    logic signed [W+16:0]  d_pm_reg;
    logic signed [W+17:0]  d_pg_reg;
    logic [UW+RB-1:0]      d_pu_reg;
    logic [UW-1:0]         d_ag_reg;
    logic signed [W-1:0]   d_w_reg;
    logic [SB-1:0]         d_scale_reg;
    logic [RB:0]           comp_rate;
    logic [W-1:0]          c_gmag;

    // stage E: new moment and norm
    logic signed [W-1:0]   e_mn_reg, e_w_reg;
    logic [UW-1:0]         e_un_reg;
    logic [SB-1:0]         e_scale_reg;
    logic signed [W+18:0]  e_sum, e_sh;
    logic signed [W-1:0]   e_mn_sat;
    logic [UW-1:0]         e_pu_sh;

    // stage F: partial products
    logic [W+SP-1:0]       f_lo_reg;
    logic [W+SB-SP-1:0]    f_hi_reg;
    side_t                 f_side_reg;
    logic [W-1:0]          e_amag;

    // stage G: numerator
    logic [NW-1:0]         g_n_reg;
    side_t                 g_side_reg;
    logic [PW-1:0]         f_prod;

    // stage H inputs
    logic [CW-1:0]         h_hi, h_un;
    side_t                 h_side;

    always_comb
    begin
        c_sum = (W+18)'(b_dec_reg >>> RB) + (W+18)'(b_g_reg);
        if (&c_sum[W+17:W-1] || ~|c_sum[W+17:W-1])
        begin
            c_g_sat = c_sum[W-1:0];
        end
        else
        begin
            c_g_sat = c_sum[W+17] ? VMIN : VMAX;
        end

        comp_rate = amx_pkg::RATE_ONE - {1'b0, moment_rate_reg};
        c_gmag    = c_g_reg[W-1] ? (~c_g_reg + 1'b1) : c_g_reg;

        e_sum = (W+19)'(d_pm_reg) + (W+19)'(d_pg_reg);
        e_sh  = e_sum >>> RB;
        if (&e_sh[W+18:W-1] || ~|e_sh[W+18:W-1])
        begin
            e_mn_sat = e_sh[W-1:0];
        end
        else
        begin
            e_mn_sat = e_sh[W+18] ? VMIN : VMAX;
        end
        e_pu_sh = UW'(d_pu_reg >> RB);

        e_amag = e_mn_reg[W-1] ? (~e_mn_reg + 1'b1) : e_mn_reg;

        f_prod = (PW'(f_hi_reg) << SP) + PW'(f_lo_reg);

        h_hi = CW'(g_n_reg[NW-1:W]);
        h_un = CW'(g_side_reg.un);
        h_side     = g_side_reg;
        h_side.ovf = (h_hi >= h_un);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_bias_reg  <= is_bias;
            a_g_reg     <= gradient;
            a_w_reg     <= param_value;
            a_m_reg     <= first_moment;
            a_u_reg     <= max_norm;
            a_scale_reg <= scale_reg;

            b_bias_reg  <= a_bias_reg;
            b_g_reg     <= a_g_reg;
            b_w_reg     <= a_w_reg;
            b_m_reg     <= a_m_reg;
            b_u_reg     <= a_u_reg;
            b_scale_reg <= a_scale_reg;
            b_dec_reg   <= $signed({1'b0, decay_rate_reg}) * a_w_reg;

            c_g_reg     <= b_bias_reg ? b_g_reg : c_g_sat;
            c_w_reg     <= b_w_reg;
            c_m_reg     <= b_m_reg;
            c_u_reg     <= b_u_reg;
            c_scale_reg <= b_scale_reg;

            d_pm_reg    <= $signed({1'b0, moment_rate_reg}) * c_m_reg;
            d_pg_reg    <= $signed({1'b0, comp_rate}) * c_g_reg;
            d_pu_reg    <= norm_rate_reg * c_u_reg;
            d_ag_reg    <= c_gmag[W-1] ? UMAX : c_gmag[UW-1:0];
            d_w_reg     <= c_w_reg;
            d_scale_reg <= c_scale_reg;

            e_mn_reg    <= e_mn_sat;
            e_un_reg    <= (d_ag_reg > e_pu_sh) ? d_ag_reg : e_pu_sh;
            e_w_reg     <= d_w_reg;
            e_scale_reg <= d_scale_reg;

            f_lo_reg        <= e_amag * e_scale_reg[SP-1:0];
            f_hi_reg        <= e_amag * e_scale_reg[SB-1:SP];
            f_side_reg.w    <= e_w_reg;
            f_side_reg.mn   <= e_mn_reg;
            f_side_reg.un   <= e_un_reg;
            f_side_reg.pos  <= !e_mn_reg[W-1] && (e_mn_reg != '0);
            f_side_reg.neg  <= e_mn_reg[W-1];
            f_side_reg.zero <= (e_un_reg == '0);
            f_side_reg.ovf  <= 1'b0;

            g_n_reg    <= NW'(f_prod >> SH);
            g_side_reg <= f_side_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [W-1:0] div_rem_reg [0:W];
    logic [W-1:0] div_num_reg [0:W];
    logic [W-1:0] div_q_reg   [0:W];
    side_t        div_side_reg [0:W];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_rem_reg[0]  <= h_hi[W-1:0];
            div_num_reg[0]  <= g_n_reg[W-1:0];
            div_q_reg[0]    <= '0;
            div_side_reg[0] <= h_side;
        end
    end

    for (genvar k = 0; k < W; k++)
    begin : g_div
        logic [W:0] trial;
        logic       take;

        assign trial = {div_rem_reg[k], div_num_reg[k][W-1]};
        assign take  = trial >= {2'b00, div_side_reg[k].un};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (advance)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                div_rem_reg[k+1]  <= take ? W'(trial - {2'b00, div_side_reg[k].un})
                                          : W'(trial);
                div_num_reg[k+1]  <= {div_num_reg[k][W-2:0], 1'b0};
                div_q_reg[k+1]    <= {div_q_reg[k][W-2:0], take};
                div_side_reg[k+1] <= div_side_reg[k];
            end
        end
    end

    // final update and saturation
    side_t               fin;
    logic [W-1:0]        delta;
    logic signed [W+1:0] wsum;
    res_t                pipe_res;

    always_comb
    begin
        fin   = div_side_reg[W];
        delta = (fin.ovf || (div_q_reg[W] > CAP)) ? CAP : div_q_reg[W];
        if (fin.pos)
        begin
            wsum = (W+2)'(fin.w) - $signed({2'b00, delta});
        end
        else
        begin
            wsum = (W+2)'(fin.w) + $signed({2'b00, delta});
        end
        pipe_res.mn   = fin.mn;
        pipe_res.un   = fin.un;
        pipe_res.zero = fin.zero;
        if (fin.zero || !(fin.pos || fin.neg))
        begin
            pipe_res.wn = fin.w;
        end
        else if (&wsum[W+1:W-1] || ~|wsum[W+1:W-1])
        begin
            pipe_res.wn = wsum[W-1:0];
        end
        else
        begin
            pipe_res.wn = wsum[W+1] ? VMIN : VMAX;
        end
    end

    // output register and skid stage
    logic out_valid_reg;
    res_t out_res_reg, skid_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= dv_reg[W];
        end
        else if (dv_reg[W])
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_res_reg <= pipe_res;
        end
        else
        begin
            skid_res_reg <= pipe_res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign new_param_value  = out_res_reg.wn;
    assign new_first_moment = out_res_reg.mn;
    assign new_max_norm     = out_res_reg.un;
    assign zero_norm        = out_res_reg.zero;

endmodule

// ===== rtl/core/amx_checker.sv =====
// Port-level checks for the AdaMax parameter update block, with its bind.
`timescale 1ns / 1ps

module amx_checker #(
    parameter int DATA_WIDTH = amx_pkg::DATA_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [DATA_WIDTH-1:0] new_param_value,
    input logic [DATA_WIDTH-2:0]        new_max_norm,
    input logic                         zero_norm
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_param_value))
        else $error("stalled result transaction changed");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> new_max_norm == '0)
        else $error("zero_norm set with nonzero max norm");

    a_zero_seen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (new_max_norm == '0) |-> zero_norm)
        else $error("zero max norm without zero_norm");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config transaction refused");

endmodule

bind adamax_parameter_update amx_checker #(.DATA_WIDTH(DATA_WIDTH)) u_amx_checker (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .new_param_value(new_param_value),
    .new_max_norm(new_max_norm),
    .zero_norm(zero_norm)
);

// ===== dv/adamax_parameter_update_checker.sv =====
// Checker for the AdaMax update block: watches the channels, predicts and compares results.
`timescale 1ns / 1ps

module adamax_parameter_update_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [amx_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [amx_pkg::RATE_BITS-1:0]       cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                start_of_pass,
    input  logic                                is_bias,
    input  logic signed [31:0]                  gradient,
    input  logic signed [31:0]                  param_value,
    input  logic signed [31:0]                  first_moment,
    input  logic [30:0]                         max_norm,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [31:0]                  new_param_value,
    input  logic signed [31:0]                  new_first_moment,
    input  logic [30:0]                         new_max_norm,
    input  logic                                zero_norm,
    output int                                  errors,
    output int                                  pending,
    output int                                  results_seen,
    output int                                  zero_norm_seen
);

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] moment;
        logic [30:0] norm;
        logic        zero;
    } update_t;

    update_t          expected_updates[$];
    logic [15:0]      eta, lambda, beta1, beta2;
    logic [63:0]      beta1_power;
    logic [47:0]      step_scale;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor16(longint v);
        return v >>> 16;
    endfunction

    task automatic predict_update(input logic sp, input logic b, input logic signed [31:0] gi,
                                  input logic signed [31:0] wi, input logic signed [31:0] mi,
                                  input logic [30:0] ui);
        longint     g, w, m, mn, wn;
        logic [63:0] ag, un, mabs, delta, factor;
        logic [127:0] num, quo;
        update_t    r;
        g = gi;
        w = wi;
        m = mi;
        wn = w;
        if (sp)
        begin
            beta1_power = (beta1_power * beta1) >> 16;
            factor = 64'h8000_0000 - beta1_power;
            if (factor == 0)
                step_scale = amx_pkg::SCALE_MAX;
            else
            begin
                num = (128'(eta) << 47) / factor;
                step_scale = (num > 128'(amx_pkg::SCALE_MAX)) ? amx_pkg::SCALE_MAX : num[47:0];
            end
        end
        if (!b)
            g = clamp32(g + floor16(longint'(lambda) * w));
        mn = clamp32(floor16(longint'(beta1) * m + (64'sd65536 - longint'(beta1)) * g));
        ag = (g < 0) ? -g : g;
        if (ag > 64'h7FFF_FFFF)
            ag = 64'h7FFF_FFFF;
        un = (64'(beta2) * ui) >> 16;
        if (ag > un)
            un = ag;
        r.zero = (un == 0);
        if (un != 0)
        begin
            mabs = (mn < 0) ? -mn : mn;
            num = (128'(mabs) * step_scale) >> 16;
            quo = num / un;
            delta = (quo > 128'h8000_0000) ? 64'h8000_0000 : quo[63:0];
            if (mn > 0)
                wn = clamp32(w - longint'(delta));
            else if (mn < 0)
                wn = clamp32(w + longint'(delta));
        end
        r.value = wn[31:0];
        r.moment = mn[31:0];
        r.norm = un[30:0];
        expected_updates.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        update_t exp_r;
        if (!rst_n)
        begin
            eta <= amx_pkg::LEARNING_RATE_RST;
            lambda <= amx_pkg::DECAY_RATE_RST;
            beta1 <= amx_pkg::MOMENT_RATE_RST;
            beta2 <= amx_pkg::NORM_RATE_RST;
            beta1_power = 64'h8000_0000;
            step_scale = '0;
            expected_updates.delete();
            errors <= 0;
            results_seen <= 0;
            zero_norm_seen <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    amx_pkg::REG_LEARNING_RATE: eta <= cfg_data;
                    amx_pkg::REG_DECAY_RATE:    lambda <= cfg_data;
                    amx_pkg::REG_MOMENT_RATE:   beta1 <= cfg_data;
                    amx_pkg::REG_NORM_RATE:     beta2 <= cfg_data;
                    default:                    ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_update(start_of_pass, is_bias, gradient, param_value,
                               first_moment, max_norm);
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (zero_norm)
                    zero_norm_seen <= zero_norm_seen + 1;
                if (expected_updates.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result transaction value=%h", new_param_value);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = expected_updates.pop_front();
                    if (exp_r.value !== new_param_value || exp_r.moment !== new_first_moment
                        || exp_r.norm !== new_max_norm || exp_r.zero !== zero_norm)
                    begin
                        if (errors < 10)
                            $display("mismatch: exp w=%h m=%h u=%h z=%b got w=%h m=%h u=%h z=%b",
                                     exp_r.value, exp_r.moment, exp_r.norm, exp_r.zero,
                                     new_param_value, new_first_moment, new_max_norm,
                                     zero_norm);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= expected_updates.size();
        end
    end

endmodule

// ===== dv/adamax_parameter_update_test.sv =====
// Testbench top for the AdaMax update block: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module adamax_parameter_update_test;

    logic                               clk = 0;
    logic                               rst_n = 0;
    logic                               cfg_valid = 0;
    logic                               cfg_ready;
    logic [amx_pkg::CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [amx_pkg::RATE_BITS-1:0]      cfg_data = '0;
    logic                               in_valid = 0;
    logic                               in_stall;
    logic                               start_of_pass = 0;
    logic                               is_bias = 0;
    logic signed [31:0]                 gradient = '0;
    logic signed [31:0]                 param_value = '0;
    logic signed [31:0]                 first_moment = '0;
    logic [30:0]                        max_norm = '0;
    logic                               out_valid;
    logic                               out_stall = 0;
    logic signed [31:0]                 new_param_value;
    logic signed [31:0]                 new_first_moment;
    logic [30:0]                        new_max_norm;
    logic                               zero_norm;
    int                                 errors, pending, results_seen, zero_norm_seen;
    bit                                 calm_phase = 0;
    bit                                 hold_receiver = 0;
    int                                 elements_sent = 0;

    always #1 clk = ~clk;

    adamax_parameter_update uut (.*);

    adamax_parameter_update_checker checker_i (.*);

    always @(posedge clk)
    begin
        int n;
        if (hold_receiver)
            out_stall <= 1;
        else if (!calm_phase && $urandom_range(0, 9) == 0)
        begin
            out_stall <= 1;
            n = $urandom_range(1, 14);
            repeat (n - 1) @(posedge clk);
        end
        else
            out_stall <= 0;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom_range(0, 131071) - 65536;
            4: return $urandom_range(0, 2047) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_register(input logic [amx_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic send_element(input logic sp, input logic b, input logic [31:0] g,
                                input logic [31:0] w, input logic [31:0] m,
                                input logic [30:0] u);
        in_valid <= 1;
        start_of_pass <= sp;
        is_bias <= b;
        gradient <= g;
        param_value <= w;
        first_moment <= m;
        max_norm <= u;
        do @(posedge clk); while (in_stall);
        elements_sent++;
    endtask

    task automatic idle_sender();
        int n;
        if (!calm_phase && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            n = $urandom_range(1, 14);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic random_pass(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_element(i == 0, $urandom_range(0, 3) == 0, pick_value(), pick_value(),
                         pick_value(), $urandom_range(0, 5) == 0 ? 31'd0 : 31'(pick_value()));
            idle_sender();
        end
    endtask

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [15:0] settings[4][4];
        settings = '{'{16'd131, 16'd0, 16'd58982, 16'd65470},
                     '{16'd65535, 16'd65535, 16'd65535, 16'd65535},
                     '{16'd1, 16'd0, 16'd1, 16'd1},
                     '{16'd4096, 16'd300, 16'd32768, 16'd60000}};
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // elements before any pass, zero norm, extremes
        send_element(0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0, 31'h100);
        send_element(0, 0, 32'h0, 32'h0, 32'h0, 31'h0);
        send_element(1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_element(0, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0);
        send_element(0, 1, 32'h0, 32'h1234_5678, 32'h0, 31'h0);
        send_element(0, 0, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 31'h1);
        send_element(1, 1, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h1);
        send_element(0, 0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555);
        send_element(0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h2AAA_AAAA);
        drain();
        for (int s = 0; s < 4; s++)
        begin
            write_register(amx_pkg::REG_LEARNING_RATE, settings[s][0]);
            write_register(amx_pkg::REG_DECAY_RATE, settings[s][1]);
            write_register(amx_pkg::REG_MOMENT_RATE, settings[s][2]);
            write_register(amx_pkg::REG_NORM_RATE, settings[s][3]);
            for (int p = 0; p < 12; p++)
                random_pass($urandom_range(2, 70));
            if (s == 1)
            begin
                hold_receiver = 1;
                fork
                    begin
                        repeat (300) @(posedge clk);
                        hold_receiver = 0;
                    end
                    random_pass(120);
                join
                drain();
            end
            drain();
        end
        calm_phase = 1;
        random_pass(100);
        drain();
        $display("covered %0d elements, %0d results, %0d with zero norm, four register settings",
                 elements_sent, results_seen, zero_norm_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
